FILE: rtl/joypad_port_matrix_read_macros.svh
// ----------------------------------------------------------------------------
// Joypad port matrix read - assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, idle in reset.
// ----------------------------------------------------------------------------
`ifndef JOYPAD_PORT_MATRIX_READ_MACROS_SVH
`define JOYPAD_PORT_MATRIX_READ_MACROS_SVH

// Plain property check on the rising edge of clk_i.
`define JPMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define JPMR_ASSERT_IMP(lbl, ante, cons, msg) \
  `JPMR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/jpmr_pkg.sv
// ----------------------------------------------------------------------------
// Joypad port matrix read - package
// Beat types, access codes, row-select decode tables and read constants.
// ----------------------------------------------------------------------------
`default_nettype none

package jpmr_pkg;

  localparam int BUTTONS_PER_PAD = 21;
  localparam int BTN_IDX_W       = $clog2(BUTTONS_PER_PAD);

  localparam logic [BTN_IDX_W-1:0] FIRE_FIRST_BTN = BTN_IDX_W'(16);
  localparam logic [BTN_IDX_W-1:0] PAUSE_BTN      = BTN_IDX_W'(20);

  localparam logic [15:0] ALL_ONES    = 16'hFFFF;
  localparam logic [15:0] FIRE_BASE   = 16'hFF6F;
  localparam int          NTSC_BIT    = 4;
  localparam int          PAD0_BTN_LO = 8;
  localparam int          PAD1_BTN_LO = 12;
  localparam logic [3:0]  PAD1_MARK_TOP = 4'd7;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    OFF_MATRIX  = 2'd0,
    OFF_ROW_SEL = 2'd1,
    OFF_FIRE    = 2'd2,
    OFF_TAIL    = 2'd3
  } offset_e;

  typedef struct packed {
    op_e                        operation;
    offset_e                    word_offset;
    logic [15:0]                write_data;
    logic [BUTTONS_PER_PAD-1:0] pad0_buttons;
    logic [BUTTONS_PER_PAD-1:0] pad1_buttons;
  } jpmr_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        audio_on;
  } jpmr_out_t;

  // Port state that is visible to reads or to the result.
  typedef struct packed {
    logic [7:0] row_sel;   // byte 1: pad 0 low nibble, pad 1 high nibble
    logic       pads_en;
    logic       audio_en;
  } port_state_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
  } row_sel_t;

  function automatic row_sel_t pad0_row_decode(input logic [3:0] nib);
    row_sel_t r;
    r = '0;
    unique case (nib)
      4'd7:    r = '{hit: 1'b1, row: 2'd3};
      4'd11:   r = '{hit: 1'b1, row: 2'd2};
      4'd13:   r = '{hit: 1'b1, row: 2'd1};
      4'd14:   r = '{hit: 1'b1, row: 2'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic row_sel_t pad1_row_decode(input logic [3:0] nib);
    row_sel_t r;
    r = '0;
    unique case (nib)
      4'd7:    r = '{hit: 1'b1, row: 2'd0};
      4'd11:   r = '{hit: 1'b1, row: 2'd1};
      4'd13:   r = '{hit: 1'b1, row: 2'd2};
      4'd14:   r = '{hit: 1'b1, row: 2'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/jpmr_port_regs.sv
// ----------------------------------------------------------------------------
// Joypad port matrix read - port registers
// Row-select byte, pad enable and audio enable, updated by write beats.
// ----------------------------------------------------------------------------
`default_nettype none

module jpmr_port_regs import jpmr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire offset_e     word_offset_i,
  input  wire logic [15:0] write_data_i,
  output port_state_t      state_o,
  output port_state_t      state_next_o
);

  port_state_t state_q;
  port_state_t state_d;

  // Bytes 2 and 3 are never read back; byte 1 and the enable bits of byte 0 are kept.
  always_comb begin
    state_d = state_q;
    if (wr_en_i) begin
      unique case (word_offset_i)
        OFF_MATRIX: begin
          state_d.row_sel  = write_data_i[7:0];
          state_d.audio_en = write_data_i[8];
          state_d.pads_en  = write_data_i[15];
        end
        OFF_ROW_SEL: begin
          state_d.row_sel = write_data_i[15:8];
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (wr_en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o      = state_q;
  assign state_next_o = state_d;

endmodule

`default_nettype wire

FILE: rtl/jpmr_read_decode.sv
// ----------------------------------------------------------------------------
// Joypad port matrix read - read decode
// Row lookup and active-low button, marker and fire/pause bit assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module jpmr_read_decode import jpmr_pkg::*; (
  input  wire jpmr_in_t    beat_i,
  input  wire port_state_t state_i,
  input  wire logic        ntsc_i,
  output logic [15:0]      read_data_o
);

  row_sel_t    r0;
  row_sel_t    r1;
  logic [15:0] matrix;
  logic [15:0] fire;

  always_comb begin
    r0     = pad0_row_decode(state_i.row_sel[3:0]);
    r1     = pad1_row_decode(state_i.row_sel[7:4]);
    matrix = ALL_ONES;
    fire   = FIRE_BASE;
    fire[NTSC_BIT] = ntsc_i;

    if (state_i.pads_en) begin
      if (r0.hit) begin
        for (int i = 0; i < 4; i++) begin
          if (beat_i.pad0_buttons[BTN_IDX_W'({r0.row, 2'(i)})]) begin
            matrix[4'(PAD0_BTN_LO + i)] = 1'b0;
          end
        end
        // row 0 has no marker bit on pad 0
        if (r0.row != 2'd0) begin
          matrix[{2'b00, r0.row}] = 1'b0;
        end
        if (beat_i.pad0_buttons[FIRE_FIRST_BTN + BTN_IDX_W'(r0.row)]) begin
          fire[1] = 1'b0;
        end
        if (r0.row == 2'd0 && beat_i.pad0_buttons[PAUSE_BTN]) begin
          fire[0] = 1'b0;
        end
      end
      if (r1.hit) begin
        for (int i = 0; i < 4; i++) begin
          if (beat_i.pad1_buttons[BTN_IDX_W'({r1.row, 2'(i)})]) begin
            matrix[4'(PAD1_BTN_LO + i)] = 1'b0;
          end
        end
        matrix[PAD1_MARK_TOP - {2'b00, r1.row}] = 1'b0;
        if (beat_i.pad1_buttons[FIRE_FIRST_BTN + BTN_IDX_W'(r1.row)]) begin
          fire[3] = 1'b0;
        end
        if (r1.row == 2'd0 && beat_i.pad1_buttons[PAUSE_BTN]) begin
          fire[2] = 1'b0;
        end
      end
    end

    if (beat_i.operation == OP_WRITE) begin
      read_data_o = '0;
    end else begin
      case (beat_i.word_offset)
        OFF_MATRIX: read_data_o = matrix;
        OFF_FIRE:   read_data_o = fire;
        default:    read_data_o = ALL_ONES;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/joypad_port_matrix_read.sv
// ----------------------------------------------------------------------------
// Joypad port matrix read - top level
// Two-pad button-matrix port: one bus word access in, one result beat out.
// ----------------------------------------------------------------------------
// Path: each beat is registered in the input reg, then in the result reg,
// and is offered on the result channel from the result reg.
// Throughput: 1 beat per cycle while the result channel is not stalled.
// A stalled result holds; the input stage keeps taking beats until it is full.
// Reset (async, active low): pipeline empty, row select, pad and audio
// enables cleared, NTSC flag set.
// ----------------------------------------------------------------------------
`default_nettype none

module joypad_port_matrix_read import jpmr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // input channel
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire jpmr_in_t in_beat_i,
  // result channel
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output jpmr_out_t     out_beat_o,
  // configuration: NTSC machine flag
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i
);

  // Stage 1: registered input beat.
  logic      s1_valid_q;
  jpmr_in_t  s1_beat_q;
  // Stage 2: registered result beat.
  logic      out_valid_q;
  jpmr_out_t out_beat_q;
  jpmr_out_t out_beat_d;

  logic ntsc_q;

  logic out_ready;
  logic s1_ready;
  logic in_fire;
  logic s1_fire;
  logic wr_en;

  port_state_t state;
  port_state_t state_next;
  logic [15:0] read_data;

  // Ready ripples back: result reg free or draining frees stage 1.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_fire    = in_valid_i && s1_ready;
  assign s1_fire    = s1_valid_q && out_ready;

  // State changes exactly when the beat moves into the result reg, so the
  // next beat in stage 1 sees the new state, in order.
  assign wr_en = s1_fire && (s1_beat_q.operation == OP_WRITE);

  jpmr_port_regs u_port_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .word_offset_i(s1_beat_q.word_offset),
    .write_data_i (s1_beat_q.write_data),
    .state_o      (state),
    .state_next_o (state_next)
  );

  // Reads look at the state before this beat.
  jpmr_read_decode u_read_decode (
    .beat_i     (s1_beat_q),
    .state_i    (state),
    .ntsc_i     (ntsc_q),
    .read_data_o(read_data)
  );

  // audio_on reports the enable after this access.
  always_comb begin
    out_beat_d.read_data = read_data;
    out_beat_d.audio_on  = state_next.audio_en;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload regs, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_beat_q <= in_beat_i;
    end
    if (s1_fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ntsc_q <= 1'b1;
    end else if (cfg_we_i) begin
      ntsc_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

FILE: rtl/jpmr_checker.sv
// ----------------------------------------------------------------------------
// Joypad port matrix read - port checker
// Watches the top-level ports for pipeline ordering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "joypad_port_matrix_read_macros.svh"

module jpmr_checker import jpmr_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire jpmr_out_t out_beat_o
);

  `JPMR_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)), "stalled result beat changed")

  `JPMR_ASSERT_IMP(a_empty_no_stall, !out_valid_o, !in_stall_o, "input stalled with empty result reg")

  `JPMR_ASSERT_IMP(a_rise_from_accept, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result beat without input beat two cycles before")

endmodule

bind joypad_port_matrix_read jpmr_checker u_jpmr_checker (.*);

`default_nettype wire

FILE: bench/jpmr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joypad port matrix read - result checker
// Watches both channels and keeps its own copy of the port state. It predicts
// each result beat and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module jpmr_scoreboard import jpmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  jpmr_in_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  jpmr_out_t out_beat_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  logic [7:0] port_bytes [4];
  logic       pads_en;
  logic       audio_en;
  logic       ntsc;
  jpmr_out_t  expected_q [$];
  int         mismatches = 0;

  // {hit, row} for one row-select nibble; the pad 1 table runs in reverse.
  function automatic logic [2:0] row_pick(input logic [3:0] nib, input logic pad1);
    logic       hit;
    logic [1:0] row;
    hit = 1'b1;
    row = 2'd0;
    case (nib)
      4'd7:  row = 2'd3;
      4'd11: row = 2'd2;
      4'd13: row = 2'd1;
      4'd14: row = 2'd0;
      default: hit = 1'b0;
    endcase
    if (pad1) row = ~row;
    return {hit, row};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jpmr_out_t   want;
    logic [2:0]  sel0;
    logic [2:0]  sel1;
    logic [15:0] word;
    if (!rst_ni) begin
      foreach (port_bytes[b]) port_bytes[b] = 8'h00;
      pads_en  = 1'b0;
      audio_en = 1'b0;
      ntsc     = 1'b1;
      expected_q.delete();
      pending_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (cfg_we_i) ntsc = cfg_wdata_i;

      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: read_data %h audio_on %b",
                 out_beat_i.read_data, out_beat_i.audio_on);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_beat_i.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_beat_i.read_data);
            mismatches++;
          end
          if (out_beat_i.audio_on !== want.audio_on) begin
            $error("audio_on: expected %b, got %b", want.audio_on, out_beat_i.audio_on);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        word = 16'h0000;
        sel0 = row_pick(port_bytes[1][3:0], 1'b0);
        sel1 = row_pick(port_bytes[1][7:4], 1'b1);
        if (in_beat_i.operation == OP_WRITE) begin
          port_bytes[in_beat_i.word_offset] = in_beat_i.write_data[15:8];
          // low byte past the end of the file is lost
          if (in_beat_i.word_offset != OFF_TAIL)
            port_bytes[int'(in_beat_i.word_offset) + 1] = in_beat_i.write_data[7:0];
          if (in_beat_i.word_offset == OFF_MATRIX) begin
            audio_en = in_beat_i.write_data[8];
            pads_en  = in_beat_i.write_data[15];
          end
        end else begin
          case (in_beat_i.word_offset)
            OFF_MATRIX: begin
              word = ALL_ONES;
              if (pads_en && sel0[2]) begin
                for (int i = 0; i < 4; i++)
                  if (in_beat_i.pad0_buttons[sel0[1:0] * 4 + i]) word[8 + i] = 1'b0;
                // row marker on bits 1..3, none for row 0
                if (sel0[1:0] != 2'd0) word[sel0[1:0]] = 1'b0;
              end
              if (pads_en && sel1[2]) begin
                for (int i = 0; i < 4; i++)
                  if (in_beat_i.pad1_buttons[sel1[1:0] * 4 + i]) word[12 + i] = 1'b0;
                word[7 - sel1[1:0]] = 1'b0;
              end
            end
            OFF_FIRE: begin
              word = FIRE_BASE;
              word[NTSC_BIT] = ntsc;
              if (pads_en && sel0[2]) begin
                if (in_beat_i.pad0_buttons[int'(FIRE_FIRST_BTN) + sel0[1:0]]) word[1] = 1'b0;
                if (sel0[1:0] == 2'd0 && in_beat_i.pad0_buttons[PAUSE_BTN]) word[0] = 1'b0;
              end
              if (pads_en && sel1[2]) begin
                if (in_beat_i.pad1_buttons[int'(FIRE_FIRST_BTN) + sel1[1:0]]) word[3] = 1'b0;
                if (sel1[1:0] == 2'd0 && in_beat_i.pad1_buttons[PAUSE_BTN]) word[2] = 1'b0;
              end
            end
            default: word = ALL_ONES;
          endcase
        end
        want.read_data = word;
        want.audio_on  = audio_en;
        expected_q.push_back(want);
      end

      pending_o <= expected_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: bench/tb_joypad_port_matrix_read.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joypad port matrix read - testbench top
// Drives bus accesses and pad states into the port with random idle and
// stall bursts, sweeps the NTSC flag and leaves checking to jpmr_scoreboard.
// ----------------------------------------------------------------------------
module tb_joypad_port_matrix_read;
  import jpmr_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASES        = 5;
  localparam int PHASE_ACCESSES = 185;
  // nibbles that select a row; everything else selects nothing
  localparam logic [3:0] ROW_NIBBLES [4] = '{4'd7, 4'd11, 4'd13, 4'd14};

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  jpmr_in_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  jpmr_out_t out_beat;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  logic idle_on    = 1'b1;   // random bursts on both channels
  int   stall_left = 0;
  int   mismatch_count;
  int   results_pending;
  int   accesses_sent = 0;
  int   writes_sent   = 0;
  int   cycle_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  joypad_port_matrix_read dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  jpmr_scoreboard u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_beat_i       (out_beat),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  // Result side back-pressure: random bursts of stalled cycles.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hang guard.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             results_pending);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic jpmr_in_t mk_access(input op_e op, input offset_e off,
                                         input logic [15:0] wd,
                                         input logic [BUTTONS_PER_PAD-1:0] p0,
                                         input logic [BUTTONS_PER_PAD-1:0] p1);
    jpmr_in_t a;
    a.operation    = op;
    a.word_offset  = off;
    a.write_data   = wd;
    a.pad0_buttons = p0;
    a.pad1_buttons = p1;
    return a;
  endfunction

  // Mostly a live row, now and then a dead nibble.
  function automatic logic [3:0] pick_row_nibble();
    if ($urandom_range(0, 99) < 85) return ROW_NIBBLES[$urandom_range(0, 3)];
    return 4'($urandom);
  endfunction

  function automatic logic [BUTTONS_PER_PAD-1:0] pick_buttons();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return BUTTONS_PER_PAD'($urandom);
  endfunction

  // Random access, shaped so most reads see pads enabled and a row selected.
  function automatic jpmr_in_t random_access();
    jpmr_in_t a;
    int       roll;
    a.write_data   = 16'($urandom);
    a.pad0_buttons = pick_buttons();
    a.pad1_buttons = pick_buttons();
    if ($urandom_range(0, 3) == 0) begin
      a.operation   = OP_WRITE;
      a.word_offset = ($urandom_range(0, 9) < 6) ? OFF_MATRIX : offset_e'($urandom_range(1, 3));
      if (a.word_offset == OFF_MATRIX) begin
        a.write_data[7:0] = {pick_row_nibble(), pick_row_nibble()};
        // keep pads on most of the time, otherwise reads stay trivial
        if ($urandom_range(0, 9) != 0) a.write_data[15] = 1'b1;
      end else if (a.word_offset == OFF_ROW_SEL) begin
        a.write_data[15:8] = {pick_row_nibble(), pick_row_nibble()};
      end
    end else begin
      a.operation = OP_READ;
      roll = $urandom_range(0, 9);
      a.word_offset = (roll < 4) ? OFF_MATRIX :
                      (roll < 8) ? OFF_FIRE :
                      (roll == 8) ? OFF_ROW_SEL : OFF_TAIL;
    end
    return a;
  endfunction

  // One input beat; returns after an edge once in_stall reads low.
  task automatic send_access(input jpmr_in_t a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= a;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    accesses_sent++;
    if (a.operation == OP_WRITE) writes_sent++;
  endtask

  // Stop sending and wait for every outstanding result beat.
  // The first edge lets the checker count the beat just taken.
  task automatic wait_port_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  task automatic set_ntsc(input logic value);
    wait_port_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pads still disabled after reset: every offset gives its idle value.
    for (k = 0; k < 4; k++)
      send_access(mk_access(OP_READ, offset_e'(k), 16'hFFFF, '1, '1));

    // Walk all four rows on both pads, pads and audio enabled.
    for (k = 0; k < 4; k++) begin
      send_access(mk_access(OP_WRITE, OFF_MATRIX, {8'h81, ROW_NIBBLES[3 - k], ROW_NIBBLES[k]},
                            '0, '0));
      send_access(mk_access(OP_READ, OFF_MATRIX, 16'h0000, '1, 21'h0A5A5A));
      send_access(mk_access(OP_READ, OFF_FIRE, 16'h0000, '1, '1));
    end

    // Dead nibbles on both pads: nothing cleared.
    send_access(mk_access(OP_WRITE, OFF_MATRIX, 16'h8000, '0, '0));
    send_access(mk_access(OP_READ, OFF_MATRIX, 16'h0000, '1, '1));

    // Row select loaded through offset 1 (high byte lands in byte 1).
    send_access(mk_access(OP_WRITE, OFF_ROW_SEL, 16'hE7FF, '0, '0));
    send_access(mk_access(OP_READ, OFF_MATRIX, 16'h0000, '1, '0));

    // Upper bytes; the low byte of an offset-3 write is dropped.
    send_access(mk_access(OP_WRITE, OFF_FIRE, 16'hFFFF, '0, '0));
    send_access(mk_access(OP_WRITE, OFF_TAIL, 16'h12FF, '0, '0));

    // Pads off with a live row and audio on: fire read is just base + NTSC.
    send_access(mk_access(OP_WRITE, OFF_MATRIX, 16'h017E, '0, '0));
    send_access(mk_access(OP_READ, OFF_FIRE, 16'h0000, '1, '1));

    // Random phases, NTSC flag swept through both values; the last phase
    // runs with no idle or stall bursts.
    for (int phase = 0; phase < PHASES; phase++) begin
      set_ntsc((phase < 2) ? phase[0] : 1'($urandom));
      idle_on = (phase != PHASES - 1);
      for (k = 0; k < PHASE_ACCESSES; k++) begin
        // mid-phase hold-off until the pipeline has drained
        if (phase == 2 && k == PHASE_ACCESSES / 2) wait_port_idle();
        send_access(random_access());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    for (k = 0; k < 1000 && results_pending != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (results_pending != 0) $error("%0d result beats never arrived", results_pending);

    $display("Covered %0d port accesses (%0d writes) over all offsets and row selects,",
             accesses_sent, writes_sent);
    $display("both NTSC settings, with idle and stall bursts on both channels.");
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/jpmr_pkg.sv
rtl/jpmr_port_regs.sv
rtl/jpmr_read_decode.sv
rtl/joypad_port_matrix_read.sv
rtl/jpmr_checker.sv
bench/jpmr_checker.sv
bench/tb_joypad_port_matrix_read.sv
